FILE: rtl/swk_pkg.sv
// Shared types, constants and helpers for the swerve wheel command solver.
// No dependencies.
`default_nettype none
package swk_pkg;

  localparam int NUM_WHEELS     = 4;
  localparam int CORDIC_STAGES  = 16;
  localparam int WHL_W          = 2;
  localparam int IN_W           = 16;
  localparam int AW             = 16;
  localparam int DRV_W          = 20;
  localparam int VW             = 31;
  localparam int XW             = 34;
  localparam int ZW             = 25;
  localparam int QW             = 20;
  localparam int DVW            = 11;
  localparam int RW             = QW + DVW;
  localparam int WRW            = 19;

  localparam logic signed [ZW-1:0]  Z_PI        = ZW'(3294199);
  localparam logic signed [WRW-1:0] ANG_PI      = WRW'(25736);
  localparam logic signed [WRW-1:0] ANG_2PI     = WRW'(51472);
  localparam logic signed [WRW-1:0] ANG_HALF_PI = WRW'(12868);
  localparam logic [29:0]           INV_GAIN    = 30'd652032874;
  localparam logic signed [DRV_W-1:0] DRIVE_MAX = DRV_W'(524287);

  // configuration register indexes
  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_TRACK  = 3'd1;
  localparam logic [2:0] REG_OFS_X  = 3'd2;
  localparam logic [2:0] REG_OFS_Y  = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_LIMIT  = 3'd5;
  localparam logic [2:0] REG_OPT    = 3'd6;

  typedef struct packed {
    logic                 vld;
    logic [WHL_W-1:0]     whl;
    logic signed [AW-1:0] meas;
    logic                 zero;
    logic                 ovf;
    logic signed [AW-1:0] ang;
  } tag_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(823550);
      1:  v = ZW'(486170);
      2:  v = ZW'(256879);
      3:  v = ZW'(130396);
      4:  v = ZW'(65451);
      5:  v = ZW'(32757);
      6:  v = ZW'(16383);
      7:  v = ZW'(8192);
      8:  v = ZW'(4096);
      9:  v = ZW'(2048);
      10: v = ZW'(1024);
      11: v = ZW'(512);
      12: v = ZW'(256);
      13: v = ZW'(128);
      14: v = ZW'(64);
      15: v = ZW'(32);
      16: v = ZW'(16);
      17: v = ZW'(8);
      18: v = ZW'(4);
      19: v = ZW'(2);
      20: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // one step into (-pi, pi]; inputs stay within one turn of that range
  function automatic logic signed [AW-1:0] ang_wrap(input logic signed [WRW-1:0] a);
    logic signed [WRW-1:0] v;
    if (a > ANG_PI) begin
      v = a - ANG_2PI;
    end else if (a <= -ANG_PI) begin
      v = a + ANG_2PI;
    end else begin
      v = a;
    end
    return v[AW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/swk_cordic_cell.sv
// One vectoring CORDIC cell: rotates toward y = 0 by a fixed stage angle.
// Depends on swk_pkg.
`default_nettype none
module swk_cordic_cell
  import swk_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic signed [ZW-1:0] z_i,
  input  wire tag_t                 tag_i,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [ZW-1:0]      z_o,
  output tag_t                      tag_o
);

  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  tag_t                 tag_r;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + atan_q20(STAGE);
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - atan_q20(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

FILE: rtl/swk_div_cell.sv
// One restoring division cell: settles a single quotient bit.
// Depends on swk_pkg.
`default_nettype none
module swk_div_cell
  import swk_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [DVW-1:0] dvs,
  input  wire logic [RW-1:0]  rem_i,
  input  wire logic [QW-1:0]  q_i,
  input  wire tag_t           tag_i,
  output logic [RW-1:0]       rem_o,
  output logic [QW-1:0]       q_o,
  output tag_t                tag_o
);

  logic [RW-1:0] dsh, rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] q_r;
  tag_t          tag_r;

  assign dsh = RW'(dvs) << BIT;

  always_comb begin
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= dsh) begin
      rem_nxt    = rem_i - dsh;
      q_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

FILE: rtl/swerve_wheel_command_solver_top.sv
// Swerve wheel command solver top: wheel issue, velocity, CORDIC and divider rows, output.
// Depends on swk_pkg, swk_cordic_cell, swk_div_cell.
//
//  channel | direction | handshake         | beat
//  in_     | input     | in_valid/in_stall   | body command and four measured angles
//  out_    | output    | out_valid/out_stall | four drives and four steering targets
//  cfg_    | input     | cfg_valid/cfg_ready | register index and write data
//
// An item is issued as four wheels, one per cycle while the pipeline is not stalled;
// the next item is taken in the cycle that issues the last wheel of the current one.
// rst_n is synchronous; it clears valids and loads register defaults.
// A held result stalls the whole wheel pipeline only when the last wheel needs the output.
`default_nettype none
module swerve_wheel_command_solver_top
  import swk_pkg::*;
#(
  parameter int CORDIC_STAGES_P = CORDIC_STAGES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [IN_W-1:0] in_body_vel_x,
  input  wire logic signed [IN_W-1:0] in_body_vel_y,
  input  wire logic signed [IN_W-1:0] in_body_yaw_rate,
  input  wire logic signed [AW-1:0]   in_meas_angle_fl,
  input  wire logic signed [AW-1:0]   in_meas_angle_fr,
  input  wire logic signed [AW-1:0]   in_meas_angle_rl,
  input  wire logic signed [AW-1:0]   in_meas_angle_rr,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [DRV_W-1:0]     out_drive_fl,
  output logic signed [DRV_W-1:0]     out_drive_fr,
  output logic signed [DRV_W-1:0]     out_drive_rl,
  output logic signed [DRV_W-1:0]     out_drive_rr,
  output logic signed [AW-1:0]        out_steer_fl,
  output logic signed [AW-1:0]        out_steer_fr,
  output logic signed [AW-1:0]        out_steer_rl,
  output logic signed [AW-1:0]        out_steer_rr,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [14:0]            cfg_data
);

  // configuration
  logic [11:0]        base_r, track_r;
  logic signed [11:0] ofs_x_r, ofs_y_r;
  logic [9:0]         radius_r;
  logic [14:0]        limit_r;
  logic               opt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= 12'd500;
      track_r  <= 12'd500;
      ofs_x_r  <= '0;
      ofs_y_r  <= '0;
      radius_r <= 10'd50;
      limit_r  <= 15'd17014;
      opt_r    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE:   base_r   <= cfg_data[11:0];
        REG_TRACK:  track_r  <= cfg_data[11:0];
        REG_OFS_X:  ofs_x_r  <= cfg_data[11:0];
        REG_OFS_Y:  ofs_y_r  <= cfg_data[11:0];
        REG_RADIUS: radius_r <= cfg_data[9:0];
        REG_LIMIT:  limit_r  <= cfg_data[14:0];
        REG_OPT:    opt_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  tag_t dv_tag [QW+1];
  logic out_valid_r;

  assign en = !(dv_tag[QW].vld && (dv_tag[QW].whl == WHL_W'(NUM_WHEELS - 1)) &&
                out_valid_r && out_stall);

  // item hold and wheel issue
  logic                   busy_r, busy_nxt;
  logic [WHL_W-1:0]       whl_r, whl_nxt;
  logic                   last_issue, accept;
  logic signed [IN_W-1:0] vx_in_r, vy_in_r, yaw_in_r;
  logic signed [AW-1:0]   meas_r [NUM_WHEELS];

  assign last_issue = busy_r && en && (whl_r == WHL_W'(NUM_WHEELS - 1));
  assign in_stall   = busy_r && !last_issue;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    whl_nxt  = whl_r;
    if (busy_r && en) begin
      whl_nxt = whl_r + 1'b1;
      if (last_issue) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      whl_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      whl_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      whl_r  <= whl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_in_r   <= in_body_vel_x;
      vy_in_r   <= in_body_vel_y;
      yaw_in_r  <= in_body_yaw_rate;
      meas_r[0] <= in_meas_angle_fl;
      meas_r[1] <= in_meas_angle_fr;
      meas_r[2] <= in_meas_angle_rl;
      meas_r[3] <= in_meas_angle_rr;
    end
  end

  // wheel velocity in 1/2000 mm/s
  localparam logic signed [11:0] K2000 = 12'sd2000;
  logic signed [13:0]   hx, hy, wx, wy;
  logic signed [27:0]   pvx, pvy;
  logic signed [29:0]   pyx, pyy;
  logic signed [VW-1:0] vx_c, vy_c;
  tag_t                 a_tag_c;

  always_comb begin
    hx = whl_r[1] ? -$signed({2'b00, base_r}) : $signed({2'b00, base_r});
    hy = whl_r[0] ? -$signed({2'b00, track_r}) : $signed({2'b00, track_r});
    wx = hx - $signed({ofs_x_r[11], ofs_x_r, 1'b0});
    wy = hy - $signed({ofs_y_r[11], ofs_y_r, 1'b0});
  end

  assign pvx  = 28'(K2000) * 28'(vx_in_r);
  assign pvy  = 28'(K2000) * 28'(vy_in_r);
  assign pyx  = 30'(yaw_in_r) * 30'(wy);
  assign pyy  = 30'(yaw_in_r) * 30'(wx);
  assign vx_c = VW'(pvx) - VW'(pyx);
  assign vy_c = VW'(pvy) + VW'(pyy);

  always_comb begin
    a_tag_c      = '0;
    a_tag_c.vld  = busy_r;
    a_tag_c.whl  = whl_r;
    a_tag_c.meas = meas_r[whl_r];
  end

  logic signed [VW-1:0] a_vx_r, a_vy_r;
  tag_t                 a_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else if (en) begin
      a_tag_r <= a_tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vx_r <= vx_c;
      a_vy_r <= vy_c;
    end
  end

  // fold left half plane onto the right, flag the zero vector
  logic signed [XW-1:0] cx [CORDIC_STAGES_P+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES_P+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES_P+1];
  tag_t                 ct [CORDIC_STAGES_P+1];
  logic signed [XW-1:0] b_x_r, b_y_r;
  logic signed [ZW-1:0] b_z_r;
  tag_t                 b_tag_r, b_tag_c;

  always_comb begin
    b_tag_c      = a_tag_r;
    b_tag_c.zero = (a_vx_r == '0) && (a_vy_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r <= '0;
    end else if (en) begin
      b_tag_r <= b_tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_vx_r[VW-1]) begin
        b_x_r <= -XW'(a_vx_r);
        b_y_r <= -XW'(a_vy_r);
        b_z_r <= a_vy_r[VW-1] ? -Z_PI : Z_PI;
      end else begin
        b_x_r <= XW'(a_vx_r);
        b_y_r <= XW'(a_vy_r);
        b_z_r <= '0;
      end
    end
  end

  assign cx[0] = b_x_r;
  assign cy[0] = b_y_r;
  assign cz[0] = b_z_r;
  assign ct[0] = b_tag_r;

  for (genvar g = 0; g < CORDIC_STAGES_P; g++) begin : g_cordic
    swk_cordic_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .x_i   (cx[g]),
      .y_i   (cy[g]),
      .z_i   (cz[g]),
      .tag_i (ct[g]),
      .x_o   (cx[g+1]),
      .y_o   (cy[g+1]),
      .z_o   (cz[g+1]),
      .tag_o (ct[g+1])
    );
  end

  // angle rounding, magnitude scale split into two partial products
  logic signed [ZW-1:0]    zr;
  logic signed [ZW-8:0]    zs;
  logic [46:0]             m_pl_r;
  logic [45:0]             m_ph_r;
  tag_t                    m_tag_r, m_tag_c;

  assign zr = cz[CORDIC_STAGES_P] + ZW'(64);
  assign zs = zr[ZW-1:7];

  always_comb begin
    m_tag_c     = ct[CORDIC_STAGES_P];
    m_tag_c.ang = m_tag_c.zero ? '0 : ang_wrap(WRW'(zs));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r <= '0;
    end else if (en) begin
      m_tag_r <= m_tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pl_r <= 47'(cx[CORDIC_STAGES_P][16:0]) * 47'(INV_GAIN);
      m_ph_r <= 46'(cx[CORDIC_STAGES_P][XW-2:17]) * 46'(INV_GAIN);
    end
  end

  // sum partials, add radius for rounding, check quotient range
  logic [63:0]    msum;
  logic [33:0]    mag;
  logic [34:0]    num;
  logic [DVW-1:0] dvs;
  tag_t           n_tag_c;
  logic [RW-1:0]  dv_rem [QW+1];
  logic [QW-1:0]  dv_q   [QW+1];
  logic [RW-1:0]  n_rem_r;
  tag_t           n_tag_r;

  assign msum = {1'b0, m_ph_r, 17'b0} + 64'(m_pl_r) + 64'd536870912;
  assign mag  = msum[63:30];
  assign num  = {1'b0, mag} + 35'(radius_r);
  assign dvs  = {radius_r, 1'b0};

  always_comb begin
    n_tag_c     = m_tag_r;
    n_tag_c.ovf = num[34:QW-1] >= 16'(dvs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_tag_r <= '0;
    end else if (en) begin
      n_tag_r <= n_tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_rem_r <= num[RW-1:0];
    end
  end

  assign dv_rem[0] = n_rem_r;
  assign dv_q[0]   = '0;
  assign dv_tag[0] = n_tag_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    swk_div_cell #(.BIT(QW - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dvs   (dvs),
      .rem_i (dv_rem[g]),
      .q_i   (dv_q[g]),
      .tag_i (dv_tag[g]),
      .rem_o (dv_rem[g+1]),
      .q_o   (dv_q[g+1]),
      .tag_o (dv_tag[g+1])
    );
  end

  // reversal optimization
  tag_t                  p_tag;
  logic signed [DRV_W-1:0] drv0, drv_fin;
  logic signed [AW-1:0]  dang, ang1, ang_fin;
  logic signed [WRW-1:0] lim;
  logic                  rev1, rev2;

  assign p_tag = dv_tag[QW];
  assign lim   = WRW'(limit_r);

  always_comb begin
    if (radius_r == '0) begin
      drv0 = '0;
    end else if (p_tag.ovf) begin
      drv0 = DRIVE_MAX;
    end else begin
      drv0 = dv_q[QW];
    end
    dang = ang_wrap(WRW'(p_tag.ang) - WRW'(p_tag.meas));
    rev1 = opt_r && ((WRW'(dang) > ANG_HALF_PI) || (WRW'(dang) < -ANG_HALF_PI));
    ang1 = rev1 ? ang_wrap(WRW'(p_tag.ang) + ANG_PI) : p_tag.ang;
    rev2 = opt_r && ((WRW'(ang1) > lim) || (WRW'(ang1) < -lim));
    ang_fin = rev2 ? ang_wrap(WRW'(ang1) + ANG_PI) : ang1;
    drv_fin = (rev1 ^ rev2) ? -drv0 : drv0;
  end

  // assemble wheels, present result
  logic signed [DRV_W-1:0] acc_drv_r [NUM_WHEELS-1];
  logic signed [AW-1:0]    acc_ang_r [NUM_WHEELS-1];
  logic signed [DRV_W-1:0] o_drv_r [NUM_WHEELS];
  logic signed [AW-1:0]    o_ang_r [NUM_WHEELS];
  logic                    load_out, out_valid_nxt;

  assign load_out = en && p_tag.vld && (p_tag.whl == WHL_W'(NUM_WHEELS - 1));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p_tag.vld && !load_out) begin
      acc_drv_r[p_tag.whl] <= drv_fin;
      acc_ang_r[p_tag.whl] <= ang_fin;
    end
    if (load_out) begin
      for (int i = 0; i < NUM_WHEELS - 1; i++) begin
        o_drv_r[i] <= acc_drv_r[i];
        o_ang_r[i] <= acc_ang_r[i];
      end
      o_drv_r[NUM_WHEELS-1] <= drv_fin;
      o_ang_r[NUM_WHEELS-1] <= ang_fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_drive_fl = o_drv_r[0];
  assign out_drive_fr = o_drv_r[1];
  assign out_drive_rl = o_drv_r[2];
  assign out_drive_rr = o_drv_r[3];
  assign out_steer_fl = o_ang_r[0];
  assign out_steer_fr = o_ang_r[1];
  assign out_steer_rl = o_ang_r[2];
  assign out_steer_rr = o_ang_r[3];

endmodule
`default_nettype wire

FILE: test/tb_swerve_wheel_command_solver_top.sv
// Self-checking testbench for the swerve wheel command solver top.
// Depends on swk_pkg and swerve_wheel_command_solver_top; predicts each beat in-bench.
`timescale 1ns / 1ps
module tb_swerve_wheel_command_solver_top;
  import swk_pkg::*;

  typedef struct {
    logic signed [15:0] vx, vy, yaw;
    logic signed [15:0] meas [4];
  } cmd_t;

  typedef struct {
    logic signed [19:0] drive [4];
    logic signed [15:0] steer [4];
  } wheel_cmd_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_body_vel_x = 0, in_body_vel_y = 0, in_body_yaw_rate = 0;
  logic signed [15:0] in_meas_angle_fl = 0, in_meas_angle_fr = 0;
  logic signed [15:0] in_meas_angle_rl = 0, in_meas_angle_rr = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [19:0] out_drive_fl, out_drive_fr, out_drive_rl, out_drive_rr;
  logic signed [15:0] out_steer_fl, out_steer_fr, out_steer_rl, out_steer_rr;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_BASE;
  logic [14:0] cfg_data = 0;

  swerve_wheel_command_solver_top dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  longint base_mm, track_mm, ofs_x_mm, ofs_y_mm, radius_mm, limit_q13;
  bit opt_en;

  wheel_cmd_t expected_cmds [$];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  int hold_cycles = 0;
  bit hold_req = 0;

  localparam longint ATAN [16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                   8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_q13(longint a);
    while (a > 25736) a -= 51472;
    while (a <= -25736) a += 51472;
    return a;
  endfunction

  function automatic wheel_cmd_t solve_wheels(cmd_t c);
    wheel_cmd_t r;
    longint hx, hy, wx, wy, x, y, z, xs, ys, mag, ang, drv, d, meas;
    for (int w = 0; w < 4; w++) begin
      meas = c.meas[w];
      hx = w[1] ? -base_mm : base_mm;
      hy = w[0] ? -track_mm : track_mm;
      wx = hx - 2 * ofs_x_mm;
      wy = hy - 2 * ofs_y_mm;
      x = 2000 * longint'(c.vx) - longint'(c.yaw) * wy;
      y = 2000 * longint'(c.vy) + longint'(c.yaw) * wx;
      z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        ang = 0;
      end else begin
        if (x < 0) begin
          z = (y >= 0) ? 3294199 : -3294199;
          x = -x;
          y = -y;
        end
        for (int i = 0; i < 16; i++) begin
          xs = asr(x, i);
          ys = asr(y, i);
          if (y >= 0) begin
            x = x + ys; y = y - xs; z += ATAN[i];
          end else begin
            x = x - ys; y = y + xs; z -= ATAN[i];
          end
        end
        mag = asr(x * 652032874 + (longint'(1) << 29), 30);
        ang = wrap_q13(asr(z + 64, 7));
      end
      drv = 0;
      if (radius_mm != 0) begin
        drv = (mag + radius_mm) / (2 * radius_mm);
        if (drv > 524287) drv = 524287;
      end
      if (opt_en) begin
        d = wrap_q13(ang - meas);
        if (d > 12868 || d < -12868) begin
          drv = -drv; ang = wrap_q13(ang + 25736);
        end
        if (ang > limit_q13 || ang < -limit_q13) begin
          drv = -drv; ang = wrap_q13(ang + 25736);
        end
      end
      r.drive[w] = drv[19:0];
      r.steer[w] = ang[15:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic signed [19:0] got, logic signed [19:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall and long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_off) begin
      hold_off <= 1;
      hold_cycles <= 0;
    end else if (hold_off) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) hold_off <= 0;
    end
    out_stall <= hold_req || hold_off || ($urandom_range(99) < stall_pct);
  end

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    wheel_cmd_t e;
    logic signed [19:0] gd [4];
    logic signed [15:0] gs [4];
    if (rst_n && out_valid && !out_stall) begin
      gd = '{out_drive_fl, out_drive_fr, out_drive_rl, out_drive_rr};
      gs = '{out_steer_fl, out_steer_fr, out_steer_rl, out_steer_rr};
      if (expected_cmds.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycles);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (gd[w] !== e.drive[w]) report($sformatf("drive[%0d]", w), gd[w], e.drive[w]);
          if (gs[w] !== e.steer[w]) report($sformatf("steer[%0d]", w), gs[w], e.steer[w]);
        end
      end
    end
  end

  // valid stays high after a beat; an idle cycle or drain drops it
  task automatic send_cmd(cmd_t c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_body_vel_x <= c.vx;
    in_body_vel_y <= c.vy;
    in_body_yaw_rate <= c.yaw;
    in_meas_angle_fl <= c.meas[0];
    in_meas_angle_fr <= c.meas[1];
    in_meas_angle_rl <= c.meas[2];
    in_meas_angle_rr <= c.meas[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cmds.push_back(solve_wheels(c));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[14:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE:   base_mm = val & 12'hFFF;
      REG_TRACK:  track_mm = val & 12'hFFF;
      REG_OFS_X:  ofs_x_mm = longint'($signed(val[11:0]));
      REG_OFS_Y:  ofs_y_mm = longint'($signed(val[11:0]));
      REG_RADIUS: radius_mm = val & 10'h3FF;
      REG_LIMIT:  limit_q13 = val & 15'h7FFF;
      REG_OPT:    opt_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(longint b, longint t, longint ox, longint oy, longint r,
                              longint lim, longint opt);
    write_reg(REG_BASE, b);
    write_reg(REG_TRACK, t);
    write_reg(REG_OFS_X, ox);
    write_reg(REG_OFS_Y, oy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_OPT, opt);
    cfg_valid <= 0;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    // moderate speeds half the time, otherwise full-range values or pure yaw
    case ($urandom_range(3))
      0: begin
        c.vx = $urandom; c.vy = $urandom; c.yaw = $urandom;
      end
      1: begin
        c.vx = 0; c.vy = 0; c.yaw = $urandom;
      end
      default: begin
        c.vx = $signed(16'($urandom_range(4000))) - 2000;
        c.vy = $signed(16'($urandom_range(4000))) - 2000;
        c.yaw = $signed(16'($urandom_range(4000))) - 2000;
      end
    endcase
    for (int w = 0; w < 4; w++)
      c.meas[w] = ($urandom_range(9) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(51472) - 25736);
    return c;
  endfunction

  function automatic cmd_t make_cmd(int vx, int vy, int yaw, int m);
    cmd_t c;
    c.vx = vx; c.vy = vy; c.yaw = yaw;
    for (int w = 0; w < 4; w++) c.meas[w] = m;
    return c;
  endfunction

  task automatic test_directed();
    cmd_t c;
    send_cmd(make_cmd(0, 0, 0, 0));                 // zero vector
    send_cmd(make_cmd(1024, 0, 0, 0));
    send_cmd(make_cmd(-1024, 0, 0, 0));             // reversal by angle error
    send_cmd(make_cmd(0, 1024, 0, 0));
    send_cmd(make_cmd(0, -1024, 0, 25736));
    send_cmd(make_cmd(-1024, -1, 0, -25736));       // negative x, negative y
    send_cmd(make_cmd(32767, 32767, 32767, 25736));
    send_cmd(make_cmd(-32768, -32768, -32768, -25736));
    send_cmd(make_cmd(0, 0, 1024, 12868));
    send_cmd(make_cmd(0, 0, -32768, -12868));
    c = make_cmd(500, -700, 300, 0);
    c.meas = '{16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001};  // two measures out of range, two just off zero
    send_cmd(c);
    drain();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(4095, 4095, -2048, 2047, 0, 0, 1);     // zero radius, zero limit
    send_cmd(make_cmd(32767, -32768, 32767, 0));
    send_cmd(make_cmd(100, 100, 100, 100));
    drain();
    set_geometry(0, 0, 2047, -2048, 1, 25736, 1);       // radius 1 saturates drive
    send_cmd(make_cmd(-32768, 32767, -32768, 0));
    send_cmd(make_cmd(1, 0, 0, 0));
    drain();
    set_geometry(500, 500, 0, 0, 1023, 32767, 0);       // raw commands, limit above pi
    send_cmd(make_cmd(-2000, 50, 700, 25736));
    send_cmd(make_cmd(32767, 0, 0, -25736));
    drain();
  endtask

  task automatic test_random_phase(int n, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < n; i++) send_cmd(random_cmd());
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    for (int i = 0; i < 40; i++) send_cmd(random_cmd());
    drain();
  endtask

  task automatic randomize_config();
    set_geometry($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), $urandom_range(1023), $urandom_range(25736),
                 $urandom_range(1));
  endtask

  initial begin
    base_mm = 500; track_mm = 500; ofs_x_mm = 0; ofs_y_mm = 0;
    radius_mm = 50; limit_q13 = 17014; opt_en = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_geometry_extremes();
    set_geometry(500, 500, 0, 0, 50, 17014, 1);
    test_random_phase(300, 0, 0);
    randomize_config();
    test_random_phase(300, 64, 0);
    randomize_config();
    test_random_phase(300, 0, 64);
    randomize_config();
    test_random_phase(300, 36, 36);
    test_backpressure();
    set_geometry(320, 410, -30, 25, 40, 12000, 1);
    test_random_phase(350, 36, 36);
    randomize_config();
    test_random_phase(340, 0, 0);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: swerve_wheel_command_solver_top.f
rtl/swk_pkg.sv
rtl/swk_cordic_cell.sv
rtl/swk_div_cell.sv
rtl/swerve_wheel_command_solver_top.sv
test/tb_swerve_wheel_command_solver_top.sv
